@@ hw/rtl/htld_pkg.sv @@
// Shared types and constants for the Huffman tree loader and decoder.
`default_nettype none

package htld_pkg;

  localparam int SYMBOL_WIDTH = 8;
  localparam int MAX_LEAVES   = 256;
  localparam int NODE_CAP     = 2 * MAX_LEAVES - 1;
  localparam int NODE_W       = $clog2(NODE_CAP);
  localparam int CNT_W        = $clog2(NODE_CAP + 1);
  localparam int STK_W        = $clog2(MAX_LEAVES + 1);
  localparam int STK_AW       = $clog2(MAX_LEAVES);
  localparam int VAL_W        = (NODE_W > SYMBOL_WIDTH) ? NODE_W : SYMBOL_WIDTH;

  localparam logic [1:0] KIND_TREE  = 2'd0;
  localparam logic [1:0] KIND_BIT   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [2:0] ST_SYMBOL  = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_NO_TREE = 3'd2;
  localparam logic [2:0] ST_OVF     = 3'd3;
  localparam logic [2:0] ST_EXTRA   = 3'd4;
  localparam logic [2:0] ST_SINGLE  = 3'd5;

  typedef struct packed {
    logic [1:0]              kind;
    logic                    bit_req;
    logic [SYMBOL_WIDTH-1:0] leaf_symbol;
  } in_item_t;

  typedef struct packed {
    logic [SYMBOL_WIDTH-1:0] symbol;
    logic [2:0]              status;
  } out_item_t;

  // One child link of an internal node: index of an internal child, or leaf symbol
  typedef struct packed {
    logic             internal;
    logic [VAL_W-1:0] val;
  } child_t;

  // Open parent on the stack
  typedef struct packed {
    logic [NODE_W-1:0] idx;
    logic              left_done;
  } stk_entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/htld_ram.sv @@
// Generic single-write, single-read RAM with registered, write-first read.
`default_nettype none

module htld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/huffman_tree_load_and_decode.sv @@
// Huffman tree loader (preorder) and bit-serial decoder, top level.
//
// Takes one item per cycle unless a result waits under out_stall, and answers each
// item with at most one result in the next cycle. Tree items are linked under the
// open parent held in a top-of-stack register; the rest of the parent stack lives
// in a RAM whose read port is kept pointed at the entry just below the top. Each
// internal node keeps its two children in two RAMs (child zero, child one); a child
// link holds either the child's node index or, for a leaf, its symbol, so one
// message bit needs only the entry of the current node. That entry is prefetched
// on the read port addressed by the next current node, which lets a bit follow in
// the next cycle. A clear item empties the tree at once; there is no clearing pass,
// since only entries written for the present tree are ever read.
`default_nettype none

module huffman_tree_load_and_decode (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire htld_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output htld_pkg::out_item_t      out_data
);

  logic [htld_pkg::CNT_W-1:0]  node_count_r, node_count_nxt;
  logic [htld_pkg::STK_W-1:0]  depth_r, depth_nxt;
  logic                        tree_ready_r, tree_ready_nxt;
  logic [htld_pkg::NODE_W-1:0] current_r, current_nxt;
  htld_pkg::stk_entry_t        top_r, top_nxt;
  logic                        out_valid_r;
  htld_pkg::out_item_t         out_data_r;

  logic                        acc;
  logic                        res_v;
  htld_pkg::out_item_t         res;
  logic [htld_pkg::NODE_W-1:0] new_idx;
  htld_pkg::child_t            new_child;
  htld_pkg::child_t            c0_rd, c1_rd, sel;
  logic                        c0_we, c1_we;
  logic                        stk_we;
  htld_pkg::stk_entry_t        stk_wd, stk_rd;
  logic [htld_pkg::STK_W-1:0]  stk_wa_full, stk_ra_full;

  assign acc      = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;
  assign new_idx  = node_count_r[htld_pkg::NODE_W-1:0];

  always_comb begin
    new_child.internal = in_data.bit_req;
    if (in_data.bit_req) begin
      new_child.val = htld_pkg::VAL_W'(new_idx);
    end else begin
      new_child.val = htld_pkg::VAL_W'(in_data.leaf_symbol);
    end
  end

  assign sel         = in_data.bit_req ? c1_rd : c0_rd;
  assign stk_wa_full = depth_r - htld_pkg::STK_W'(1);
  assign stk_ra_full = depth_nxt - htld_pkg::STK_W'(2);
  assign stk_wd      = '{idx: top_r.idx, left_done: 1'b1};

  always_comb begin
    node_count_nxt = node_count_r;
    depth_nxt      = depth_r;
    tree_ready_nxt = tree_ready_r;
    current_nxt    = current_r;
    top_nxt        = top_r;
    c0_we          = 1'b0;
    c1_we          = 1'b0;
    stk_we         = 1'b0;
    res_v          = 1'b0;
    res            = '0;
    if (acc) begin
      case (in_data.kind)
        htld_pkg::KIND_TREE: begin
          if (tree_ready_r) begin
            res_v      = 1'b1;
            res.status = htld_pkg::ST_EXTRA;
          end else if (node_count_r == '0 && !in_data.bit_req) begin
            res_v      = 1'b1;
            res.status = htld_pkg::ST_SINGLE;
          end else if (node_count_r >= htld_pkg::CNT_W'(htld_pkg::NODE_CAP) ||
                       (in_data.bit_req &&
                        depth_r >= htld_pkg::STK_W'(htld_pkg::MAX_LEAVES))) begin
            res_v      = 1'b1;
            res.status = htld_pkg::ST_OVF;
          end else begin
            node_count_nxt = node_count_r + htld_pkg::CNT_W'(1);
            if (depth_r == '0) begin
              // first node is the root, always internal here
              top_nxt   = '{idx: new_idx, left_done: 1'b0};
              depth_nxt = htld_pkg::STK_W'(1);
            end else if (!top_r.left_done) begin
              c0_we = 1'b1;
              if (in_data.bit_req) begin
                stk_we    = 1'b1;
                top_nxt   = '{idx: new_idx, left_done: 1'b0};
                depth_nxt = depth_r + htld_pkg::STK_W'(1);
              end else begin
                top_nxt.left_done = 1'b1;
              end
            end else begin
              // right child closes the parent: pop, push again if internal
              c1_we = 1'b1;
              if (in_data.bit_req) begin
                top_nxt = '{idx: new_idx, left_done: 1'b0};
              end else begin
                top_nxt   = stk_rd;
                depth_nxt = depth_r - htld_pkg::STK_W'(1);
                if (depth_r == htld_pkg::STK_W'(1)) begin
                  tree_ready_nxt = 1'b1;
                  current_nxt    = '0;
                  res_v          = 1'b1;
                  res.status     = htld_pkg::ST_READY;
                end
              end
            end
          end
        end
        htld_pkg::KIND_BIT: begin
          if (!tree_ready_r) begin
            res_v      = 1'b1;
            res.status = htld_pkg::ST_NO_TREE;
          end else if (sel.internal) begin
            current_nxt = sel.val[htld_pkg::NODE_W-1:0];
          end else begin
            current_nxt = '0;
            res_v       = 1'b1;
            res.status  = htld_pkg::ST_SYMBOL;
            res.symbol  = sel.val[htld_pkg::SYMBOL_WIDTH-1:0];
          end
        end
        htld_pkg::KIND_CLEAR: begin
          node_count_nxt = '0;
          depth_nxt      = '0;
          tree_ready_nxt = 1'b0;
          current_nxt    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  htld_ram #(
    .WIDTH($bits(htld_pkg::child_t)),
    .DEPTH(htld_pkg::NODE_CAP)
  ) u_child0_ram (
    .clk  (clk),
    .we   (c0_we),
    .waddr(top_r.idx),
    .wdata(new_child),
    .raddr(current_nxt),
    .rdata(c0_rd)
  );

  htld_ram #(
    .WIDTH($bits(htld_pkg::child_t)),
    .DEPTH(htld_pkg::NODE_CAP)
  ) u_child1_ram (
    .clk  (clk),
    .we   (c1_we),
    .waddr(top_r.idx),
    .wdata(new_child),
    .raddr(current_nxt),
    .rdata(c1_rd)
  );

  // read port always holds the entry below the top of stack
  htld_ram #(
    .WIDTH($bits(htld_pkg::stk_entry_t)),
    .DEPTH(htld_pkg::MAX_LEAVES)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_wa_full[htld_pkg::STK_AW-1:0]),
    .wdata(stk_wd),
    .raddr(stk_ra_full[htld_pkg::STK_AW-1:0]),
    .rdata(stk_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
      depth_r      <= '0;
      tree_ready_r <= 1'b0;
      current_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      node_count_r <= node_count_nxt;
      depth_r      <= depth_nxt;
      tree_ready_r <= tree_ready_nxt;
      current_r    <= current_nxt;
      if (acc && res_v) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (acc && res_v) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= htld_pkg::STK_W'(htld_pkg::MAX_LEAVES))
    else $error("parent stack deeper than its capacity");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    tree_ready_r |-> (depth_r == '0 && node_count_r != '0))
    else $error("tree ready with open parents or no nodes");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    node_count_r <= htld_pkg::CNT_W'(htld_pkg::NODE_CAP))
    else $error("node count beyond table size");

  a_cur_in_tree: assert property (@(posedge clk) disable iff (!rst_n)
    tree_ready_r |-> (htld_pkg::CNT_W'(current_r) < node_count_r))
    else $error("current node outside the loaded tree");

  a_no_tree: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.kind == htld_pkg::KIND_BIT && !tree_ready_r)
      |=> (out_valid_r && out_data_r.status == htld_pkg::ST_NO_TREE))
    else $error("bit without tree not reported");

endmodule

`default_nettype wire
